>>> sv/vte_pkg.sv
package vte_pkg;

  localparam int CHANNELS     = 8;
  localparam int TANH_ENTRIES = 1024;
  localparam int SINE_ENTRIES = 256;

  localparam int SampleW  = 16;
  localparam int ChanW    = 3;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;
  localparam int AccW     = 24;
  localparam int ChIdxW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int TanhIdxW = $clog2(TANH_ENTRIES);
  localparam int SineIdxW = $clog2(SINE_ENTRIES);

  typedef logic [63:0]        u64_t;
  typedef logic signed [63:0] s64_t;

  typedef enum logic [CfgIdxW-1:0] {
    CfgProfile   = 2'd0,
    CfgBlend     = 2'd1,
    CfgIntensity = 2'd2,
    CfgModStep   = 2'd3
  } cfg_idx_e;

  localparam logic [1:0] ProfileRobot = 2'd3;

  localparam logic [15:0] HpCoef     [4] = '{16'd62915, 16'd63898, 16'd60948, 16'd63570};
  localparam logic [13:0] LpCoef     [4] = '{14'd7864, 14'd5243, 14'd13107, 14'd5898};
  localparam logic [17:0] DriveBase  [4] = '{18'd65536, 18'd78643, 18'd65536, 18'd98304};
  localparam logic [17:0] DriveSlope [4] = '{18'd117965, 18'd131072, 18'd85197, 18'd163840};

  localparam int TremBase  = 22938;
  localparam int TremDepth = 9830;
  localparam int SmoothNew = 55706;
  localparam int SmoothOld = 9830;

  typedef struct packed {
    logic [15:0]              phase;
    logic signed [SampleW-1:0] last_out;
    logic signed [AccW-1:0]    acc;
    logic signed [SampleW-1:0] last_in;
  } ch_state_t;

  localparam int StateW = $bits(ch_state_t);

  typedef logic signed [SampleW-1:0] tanh_tab_t [TANH_ENTRIES];
  typedef logic signed [SampleW-1:0] sine_tab_t [SINE_ENTRIES];

  localparam u64_t One30 = 64'd1 << 30;
  localparam u64_t PiQ30 = 64'd3373259426;

  // shift and subtract quotient for building the tables
  function automatic u64_t udiv(u64_t n, u64_t d);
    u64_t q;
    u64_t rem;
    q = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], n[b]};
      if (rem >= d) begin
        rem = rem - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic tanh_tab_t build_tanh_table();
    tanh_tab_t tab;
    s64_t      sm;
    u64_t      m;
    u64_t      a;
    u64_t      term;
    u64_t      e;
    u64_t      r;
    u64_t      num;
    u64_t      v;
    for (int k = 0; k < TANH_ENTRIES; k++) begin
      sm = s64_t'(2 * k + 1 - TANH_ENTRIES);
      m = (sm < 0) ? u64_t'(-sm) : u64_t'(sm);
      a = udiv(m << 30, u64_t'(2 * TANH_ENTRIES));
      term = One30;
      e = One30;
      for (int i = 1; i <= 14; i++) begin
        term = udiv(term * a, u64_t'(i) * One30);
        e = e + term;
      end
      r = udiv(u64_t'(1) << 60, e);
      for (int q = 0; q < 4; q++) begin
        r = (r * r + (One30 >> 1)) >> 30;
      end
      num = u64_t'(2) * (One30 - r) * u64_t'(32767) + (One30 + r);
      v = udiv(num, u64_t'(2) * (One30 + r));
      tab[k] = (sm < 0) ? -v[15:0] : v[15:0];
    end
    return tab;
  endfunction

  function automatic sine_tab_t build_sine_table();
    sine_tab_t tab;
    s64_t      f4;
    logic      neg;
    u64_t      x;
    u64_t      term;
    s64_t      sum;
    s64_t      v;
    for (int k = 0; k < SINE_ENTRIES; k++) begin
      f4 = s64_t'(4 * k);
      neg = 1'b0;
      if (f4 >= s64_t'(2 * SINE_ENTRIES)) begin
        neg = 1'b1;
        f4 = f4 - s64_t'(2 * SINE_ENTRIES);
      end
      if (f4 > s64_t'(SINE_ENTRIES)) begin
        f4 = s64_t'(2 * SINE_ENTRIES) - f4;
      end
      x = udiv(PiQ30 * u64_t'(f4), u64_t'(2 * SINE_ENTRIES));
      term = x;
      sum = s64_t'(x);
      for (int i = 1; i <= 8; i++) begin
        term = (term * x) >> 30;
        term = udiv((term * x) >> 30, u64_t'(2 * i) * u64_t'(2 * i + 1));
        if (i[0]) begin
          sum = sum - s64_t'(term);
        end else begin
          sum = sum + s64_t'(term);
        end
      end
      v = (sum * s64_t'(32767) + s64_t'(One30 >> 1)) >>> 30;
      if (v < 0) begin
        v = '0;
      end else if (v > s64_t'(32767)) begin
        v = s64_t'(32767);
      end
      tab[k] = neg ? -v[15:0] : v[15:0];
    end
    return tab;
  endfunction

  localparam tanh_tab_t TanhTab = build_tanh_table();
  localparam sine_tab_t SineTab = build_sine_table();

  function automatic logic [ChIdxW-1:0] chan_index(logic [ChanW-1:0] ch);
    logic [ChanW-1:0] v;
    v = ch;
    for (int i = 0; i < (1 << ChanW); i++) begin
      if (int'(v) >= CHANNELS) begin
        v = v - ChanW'(CHANNELS);
      end
    end
    return ChIdxW'(v);
  endfunction

endpackage

>>> sv/vte_ram.sv
module vte_ram #(
  parameter int Width = 8,
  parameter int Depth = 2,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/voice_tone_effect_unit.sv
// Voice tone effect: one Q1.15 sample and its channel number in, one processed sample for that
// channel out (pre-emphasis, one-pole low-pass, tanh drive, tremolo in the robot profile,
// smoothing and a dry/wet blend). Per-channel history lives in a small state RAM that is read
// when a sample is taken and written back when its result is produced; entries read as zero
// until their channel is first processed, with no clearing pass after reset. One sample is in
// flight at a time: it is stepped through ten products on one shared 26x20 multiplier plus
// the state RAM read and the tanh table read, and the next sample is taken once its result
// has moved into the output register, which waits while a previous result is still stalled.
// A finished result waiting on a stalled output does not block acceptance of the next sample.
// Configuration must be written only while no sample is in flight.
module voice_tone_effect_unit import vte_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CfgIdxW-1:0]        cfg_index_i,
  input  logic [CfgDataW-1:0]       cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [SampleW-1:0] sample_in_i,
  input  logic [ChanW-1:0]          channel_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [SampleW-1:0] sample_out_o,
  output logic [ChanW-1:0]          channel_out_o
);

  typedef enum logic [4:0] {
    StIdle, StLoad, StHpMul, StHp, StDiff, StLpMul, StAcc, StProdMul, StIdx, StTab,
    StTremMul, StTrem, StSmNew, StSmOld, StSmSum, StBlDry, StBlWet, StOut
  } state_e;

  state_e state_q;

  logic [1:0]          profile_q;
  logic [15:0]         blend_q;
  logic [15:0]         intensity_q;
  logic [15:0]         mod_step_q;
  logic [CHANNELS-1:0] valid_q;

  logic                      out_valid_q;
  logic signed [SampleW-1:0] sample_out_q;
  logic [ChanW-1:0]          channel_out_q;

  logic signed [SampleW-1:0] x_q;
  logic [ChanW-1:0]          chan_q;
  logic [ChIdxW-1:0]         cidx_q;
  logic signed [SampleW-1:0] li_q;
  logic signed [AccW-1:0]    acc_q;
  logic signed [SampleW-1:0] lo_q;
  logic [15:0]               ph_q;
  logic signed [SampleW-1:0] sine_q;
  logic signed [45:0]        mul_q;
  logic signed [45:0]        sum_q;
  logic signed [AccW-1:0]    hp_q;
  logic signed [AccW:0]      diff_q;
  logic [18:0]               drive_q;
  logic signed [17:0]        gain_q;
  logic [TanhIdxW-1:0]       idx_q;
  logic signed [SampleW-1:0] tanh_q;
  logic signed [SampleW-1:0] y_q;

  logic                      in_fire;
  logic                      out_free;
  logic                      out_fire;
  logic                      robot;
  logic [16:0]               dry;
  logic [StateW-1:0]         ram_rdata;
  ch_state_t                 ent;
  ch_state_t                 wb;
  logic                      mul_en;
  logic signed [25:0]        a_op;
  logic signed [19:0]        b_op;
  logic signed [46:0]        hp_full;
  logic signed [46:0]        acc_sum;
  logic signed [AccW-1:0]    acc_next;
  logic signed [59:0]        idx_full;
  logic signed [59:0]        idx_sh;
  logic [TanhIdxW-1:0]       idx_next;
  logic [31:0]               sine_prod;
  logic signed [46:0]        trem_full;
  logic signed [46:0]        mix_full;
  logic signed [SampleW-1:0] mix_sat;

  assign in_fire  = in_valid_i && (state_q == StIdle);
  assign out_free = !out_valid_q || !out_stall_i;
  assign out_fire = (state_q == StOut) && out_free;
  assign robot    = (profile_q == ProfileRobot);
  assign dry      = 17'h10000 - {1'b0, blend_q};

  assign in_stall_o    = (state_q != StIdle);
  assign out_valid_o   = out_valid_q;
  assign sample_out_o  = sample_out_q;
  assign channel_out_o = channel_out_q;

  assign ent = valid_q[cidx_q] ? ch_state_t'(ram_rdata) : '0;

  always_comb begin
    wb.phase    = ph_q;
    wb.last_out = y_q;
    wb.acc      = acc_q;
    wb.last_in  = x_q;
  end

  vte_ram #(
    .Width(StateW),
    .Depth(CHANNELS)
  ) u_state_ram (
    .clk_i  (clk_i),
    .we_i   (out_fire),
    .waddr_i(cidx_q),
    .wdata_i(wb),
    .re_i   (in_fire),
    .raddr_i(chan_index(channel_i)),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    mul_en = 1'b1;
    a_op   = '0;
    b_op   = '0;
    case (state_q)
      StHpMul: begin
        a_op = 26'(li_q);
        b_op = $signed(20'(HpCoef[profile_q]));
      end
      StHp: begin
        a_op = $signed(26'(intensity_q));
        b_op = $signed(20'(DriveSlope[profile_q]));
      end
      StDiff: begin
        a_op = 26'(sine_q);
        b_op = 20'(TremDepth);
      end
      StLpMul: begin
        a_op = 26'(diff_q);
        b_op = $signed(20'(LpCoef[profile_q]));
      end
      StProdMul: begin
        a_op = 26'(acc_q);
        b_op = $signed(20'(drive_q));
      end
      StTremMul: begin
        a_op = 26'(tanh_q);
        b_op = 20'(gain_q);
      end
      StSmNew: begin
        a_op = 26'(y_q);
        b_op = 20'(SmoothNew);
      end
      StSmOld: begin
        a_op = 26'(lo_q);
        b_op = 20'(SmoothOld);
      end
      StBlDry: begin
        a_op = 26'(x_q);
        b_op = $signed(20'(dry));
      end
      StBlWet: begin
        a_op = 26'(y_q);
        b_op = $signed(20'(blend_q));
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    hp_full = (47'(x_q) <<< 16) - 47'(mul_q) + 47'sd512;

    acc_sum = 47'(acc_q) + ((47'(mul_q) + 47'sd32768) >>> 16);
    if (acc_sum > 47'sd8388607) begin
      acc_next = 24'sh7FFFFF;
    end else if (acc_sum < -47'sd8388608) begin
      acc_next = 24'sh800000;
    end else begin
      acc_next = acc_sum[AccW-1:0];
    end

    idx_full = (60'(mul_q) + (60'sd1 <<< 39)) * 60'(TANH_ENTRIES);
    idx_sh   = idx_full >>> 40;
    if (idx_sh < 0) begin
      idx_next = '0;
    end else if (idx_sh > 60'(TANH_ENTRIES - 1)) begin
      idx_next = TanhIdxW'(TANH_ENTRIES - 1);
    end else begin
      idx_next = idx_sh[TanhIdxW-1:0];
    end

    sine_prod = 32'(ph_q) * 32'(SINE_ENTRIES);

    trem_full = (47'(mul_q) + 47'sd16384) >>> 15;

    mix_full = (47'(sum_q) + 47'(mul_q) + 47'sd32768) >>> 16;
    if (mix_full > 47'sd32767) begin
      mix_sat = 16'sh7FFF;
    end else if (mix_full < -47'sd32768) begin
      mix_sat = 16'sh8000;
    end else begin
      mix_sat = mix_full[SampleW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      profile_q     <= '0;
      blend_q       <= '0;
      intensity_q   <= '0;
      mod_step_q    <= '0;
      valid_q       <= '0;
      out_valid_q   <= 1'b0;
      sample_out_q  <= '0;
      channel_out_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CfgProfile:   profile_q   <= cfg_data_i[1:0];
          CfgBlend:     blend_q     <= cfg_data_i;
          CfgIntensity: intensity_q <= cfg_data_i;
          CfgModStep:   mod_step_q  <= cfg_data_i;
          default: ;
        endcase
      end

      if (out_fire) begin
        out_valid_q   <= 1'b1;
        sample_out_q  <= mix_sat;
        channel_out_q <= chan_q;
        valid_q[cidx_q] <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        StIdle:    if (in_valid_i) state_q <= StLoad;
        StLoad:    state_q <= StHpMul;
        StHpMul:   state_q <= StHp;
        StHp:      state_q <= StDiff;
        StDiff:    state_q <= StLpMul;
        StLpMul:   state_q <= StAcc;
        StAcc:     state_q <= StProdMul;
        StProdMul: state_q <= StIdx;
        StIdx:     state_q <= StTab;
        StTab:     state_q <= StTremMul;
        StTremMul: state_q <= StTrem;
        StTrem:    state_q <= StSmNew;
        StSmNew:   state_q <= StSmOld;
        StSmOld:   state_q <= StSmSum;
        StSmSum:   state_q <= StBlDry;
        StBlDry:   state_q <= StBlWet;
        StBlWet:   state_q <= StOut;
        StOut:     if (out_free) state_q <= StIdle;
        default:   state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      mul_q <= 46'(a_op) * 46'(b_op);
    end
    case (state_q)
      StIdle: begin
        x_q    <= sample_in_i;
        chan_q <= channel_i;
        cidx_q <= chan_index(channel_i);
      end
      StLoad: begin
        li_q  <= ent.last_in;
        acc_q <= ent.acc;
        lo_q  <= ent.last_out;
        ph_q  <= ent.phase;
      end
      StHpMul: begin
        sine_q <= SineTab[sine_prod[16 +: SineIdxW]];
      end
      StHp: begin
        hp_q <= 24'(hp_full >>> 10);
      end
      StDiff: begin
        diff_q  <= 25'(hp_q) - 25'(acc_q);
        drive_q <= 19'(DriveBase[profile_q]) + 19'((mul_q + 46'sd32768) >>> 16);
      end
      StLpMul: begin
        gain_q <= 18'(TremBase) + 18'((mul_q + 46'sd16384) >>> 15);
      end
      StAcc: begin
        acc_q <= acc_next;
      end
      StIdx: begin
        idx_q <= idx_next;
      end
      StTab: begin
        tanh_q <= TanhTab[idx_q];
      end
      StTrem: begin
        y_q <= robot ? trem_full[SampleW-1:0] : tanh_q;
        if (robot) begin
          ph_q <= ph_q + mod_step_q;
        end
      end
      StSmOld: begin
        sum_q <= mul_q;
      end
      StSmSum: begin
        y_q <= mix_sat;
      end
      StBlWet: begin
        sum_q <= mul_q;
      end
      default: ;
    endcase
  end

endmodule

>>> sv/vte_checker.sv
module vte_checker import vte_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic signed [SampleW-1:0] sample_out_o,
  input logic [ChanW-1:0]          channel_out_o
);

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second transaction accepted while one is in flight");

  a_no_result_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |=> !$rose(out_valid_o))
    else $error("result appeared with no transaction in flight");

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled result dropped");

  a_out_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(sample_out_o) && $stable(channel_out_o))
    else $error("stalled result payload changed");

endmodule

bind voice_tone_effect_unit vte_checker u_vte_checker (.*);
